// ===== src/prs_pkg.sv =====
// Shared types and constants for the pairwise repulsion step unit.
// No dependencies; every other file except prs_isqrt refers to this package by scoped names.
package prs_pkg;

  localparam int MAX_BODIES = 256;
  localparam int IDX_W      = $clog2(MAX_BODIES);
  localparam int CNT_W      = $clog2(MAX_BODIES + 1);
  localparam int BCNT_W     = 9;
  localparam int POS_W      = 32;
  localparam int MASS_W     = 16;
  localparam int AGE_W      = 32;
  localparam int R_W        = 33;
  localparam int G_W        = 41;
  localparam int U_W        = 17;
  localparam int MAG_W      = 42;
  localparam int ACC_W      = MAG_W + CNT_W + 1;

  localparam logic [1:0] FUNC_WRITE = 2'd0;
  localparam logic [1:0] FUNC_STEP  = 2'd1;
  localparam logic [1:0] FUNC_READ  = 2'd2;

  typedef struct packed {
    logic [1:0]              func;
    logic [7:0]              body_index;
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic [MASS_W-1:0]       body_mass;
    logic [AGE_W-1:0]        body_age;
  } in_item_t;

  typedef struct packed {
    logic signed [POS_W-1:0] out_x;
    logic signed [POS_W-1:0] out_y;
    logic [MASS_W-1:0]       out_mass;
    logic [AGE_W-1:0]        out_age;
    logic                    status;
  } out_item_t;

  typedef struct packed {
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic [MASS_W-1:0]       mass;
    logic [AGE_W-1:0]        age;
  } body_t;

  // One pair result: done and skip flags, magnitudes and the direction of each component.
  typedef struct packed {
    logic             done;
    logic             skip;
    logic [MAG_W-1:0] mag_x;
    logic [MAG_W-1:0] mag_y;
    logic             x_pos;
    logic             x_neg;
    logic             y_pos;
    logic             y_neg;
  } pair_res_t;

endpackage

// ===== src/prs_mem.sv =====
// Body table: one write port, one registered read port.
// Depends on prs_pkg.
module prs_mem (
  input  logic                      clk,
  input  logic                      wr_en,
  input  logic [prs_pkg::IDX_W-1:0] wr_addr,
  input  prs_pkg::body_t            wr_data,
  input  logic [prs_pkg::IDX_W-1:0] rd_addr,
  output prs_pkg::body_t            rd_data
);

  prs_pkg::body_t mem [prs_pkg::MAX_BODIES];
  prs_pkg::body_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// ===== src/prs_isqrt.sv =====
// Iterative floor square root, two radicand bits per cycle.
// No dependencies; uses no types from prs_pkg.
module prs_isqrt (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] operand,
  output logic        done,
  output logic [31:0] root
);

  logic [63:0] xs_r, xs_nxt;
  logic [35:0] rem_r, rem_nxt;
  logic [31:0] root_r, root_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [35:0] rem_sh;
  logic [35:0] trial;

  always_comb begin
    xs_nxt   = xs_r;
    rem_nxt  = rem_r;
    root_nxt = root_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    rem_sh   = {rem_r[33:0], xs_r[63:62]};
    trial    = {2'b00, root_r, 2'b01};
    if (start) begin
      xs_nxt   = operand;
      rem_nxt  = '0;
      root_nxt = '0;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      xs_nxt = {xs_r[61:0], 2'b00};
      if (rem_sh >= trial) begin
        rem_nxt  = rem_sh - trial;
        root_nxt = {root_r[30:0], 1'b1};
      end else begin
        rem_nxt  = rem_sh;
        root_nxt = {root_r[30:0], 1'b0};
      end
      cnt_nxt = cnt_r + 6'd1;
      if (cnt_r == 6'd31) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    xs_r   <= xs_nxt;
    rem_r  <= rem_nxt;
    root_r <= root_nxt;
  end

  assign done = done_r;
  assign root = root_r;

endmodule

// ===== src/prs_div.sv =====
// Restoring divider, 64-bit dividend by nonzero 33-bit divisor.
// Quotient holds after done until the next start.
module prs_div (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [63:0]               dividend,
  input  logic [prs_pkg::R_W-1:0]   divisor,
  output logic                      done,
  output logic [63:0]               quotient
);

  logic [63:0]               q_r, q_nxt;
  logic [prs_pkg::R_W-1:0]   rem_r, rem_nxt;
  logic [prs_pkg::R_W-1:0]   d_r, d_nxt;
  logic [6:0]                cnt_r, cnt_nxt;
  logic                      busy_r, busy_nxt;
  logic                      done_r, done_nxt;
  logic [prs_pkg::R_W:0]     rem_sh;

  always_comb begin
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    d_nxt    = d_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    rem_sh   = {rem_r, q_r[63]};
    if (start) begin
      q_nxt    = dividend;
      rem_nxt  = '0;
      d_nxt    = divisor;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (rem_sh >= {1'b0, d_r}) begin
        rem_nxt = prs_pkg::R_W'(rem_sh - {1'b0, d_r});
        q_nxt   = {q_r[62:0], 1'b1};
      end else begin
        rem_nxt = rem_sh[prs_pkg::R_W-1:0];
        q_nxt   = {q_r[62:0], 1'b0};
      end
      cnt_nxt = cnt_r + 7'd1;
      if (cnt_r == 7'd63) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    d_r   <= d_nxt;
  end

  assign done     = done_r;
  assign quotient = q_r;

endmodule

// ===== src/prs_pair.sv =====
// Pair unit: displacement magnitude of one body pair, m/r^2 times unit vector.
// Depends on prs_pkg, prs_isqrt and prs_div.
module prs_pair (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  input  logic signed [prs_pkg::POS_W-1:0]  xi,
  input  logic signed [prs_pkg::POS_W-1:0]  yi,
  input  logic signed [prs_pkg::POS_W-1:0]  xj,
  input  logic signed [prs_pkg::POS_W-1:0]  yj,
  input  logic [prs_pkg::MASS_W-1:0]        mj,
  output prs_pkg::pair_res_t                res
);

  typedef enum logic [10:0] {
    P_IDLE = 11'b00000000001,
    P_ABS  = 11'b00000000010,
    P_SQ   = 11'b00000000100,
    P_SUM  = 11'b00000001000,
    P_ROOT = 11'b00000010000,
    P_CHK  = 11'b00000100000,
    P_DIV  = 11'b00001000000,
    P_G    = 11'b00010000000,
    P_GW   = 11'b00100000000,
    P_MUL  = 11'b01000000000,
    P_OUT  = 11'b10000000000
  } pstate_t;

  pstate_t state_r, state_nxt;

  logic signed [32:0]              dx_r, dx_nxt, dy_r, dy_nxt;
  logic [prs_pkg::MASS_W-1:0]      m_r, m_nxt;
  logic [31:0]                     ax_r, ax_nxt, ay_r, ay_nxt;
  logic                            s_r, s_nxt;
  logic [61:0]                     sqx_r, sqx_nxt, sqy_r, sqy_nxt;
  logic [prs_pkg::R_W-1:0]         r_r, r_nxt;
  logic [47:0]                     t_r, t_nxt;
  logic [prs_pkg::U_W-1:0]         ux_r, ux_nxt, uy_r, uy_nxt;
  logic [prs_pkg::G_W-1:0]         g_r, g_nxt;
  logic [prs_pkg::G_W+prs_pkg::U_W-1:0] px_r, px_nxt, py_r, py_nxt;
  logic [32:0]                     adx, ady;
  logic [30:0]                     axs, ays;

  logic        sq_start, sq_done;
  logic [31:0] sq_root;
  logic        dt_start, du_start;
  logic [63:0] dt_dvd, dt_q, dux_q, duy_q;
  logic        dt_done, dux_done, duy_done;

  prs_isqrt u_isqrt (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (sq_start),
    .operand ({1'b0, {1'b0, sqx_r} + {1'b0, sqy_r}}),
    .done    (sq_done),
    .root    (sq_root)
  );

  // Shared between m/r and then (m/r)/r.
  prs_div u_div_t (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (dt_start),
    .dividend (dt_dvd),
    .divisor  (r_r),
    .done     (dt_done),
    .quotient (dt_q)
  );

  prs_div u_div_ux (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (du_start),
    .dividend ({16'b0, ax_r, 16'b0}),
    .divisor  (r_r),
    .done     (dux_done),
    .quotient (dux_q)
  );

  prs_div u_div_uy (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (du_start),
    .dividend ({16'b0, ay_r, 16'b0}),
    .divisor  (r_r),
    .done     (duy_done),
    .quotient (duy_q)
  );

  always_comb begin
    state_nxt = state_r;
    dx_nxt  = dx_r;
    dy_nxt  = dy_r;
    m_nxt   = m_r;
    ax_nxt  = ax_r;
    ay_nxt  = ay_r;
    s_nxt   = s_r;
    sqx_nxt = sqx_r;
    sqy_nxt = sqy_r;
    r_nxt   = r_r;
    t_nxt   = t_r;
    ux_nxt  = ux_r;
    uy_nxt  = uy_r;
    g_nxt   = g_r;
    px_nxt  = px_r;
    py_nxt  = py_r;
    sq_start = 1'b0;
    dt_start = 1'b0;
    du_start = 1'b0;
    dt_dvd   = {16'b0, m_r, 32'b0};
    adx = dx_r[32] ? 33'(-dx_r) : 33'(dx_r);
    ady = dy_r[32] ? 33'(-dy_r) : 33'(dy_r);
    axs = s_r ? ax_r[31:1] : ax_r[30:0];
    ays = s_r ? ay_r[31:1] : ay_r[30:0];
    unique case (state_r)
      P_IDLE: begin
        if (start) begin
          dx_nxt    = {xj[31], xj} - {xi[31], xi};
          dy_nxt    = {yj[31], yj} - {yi[31], yi};
          m_nxt     = mj;
          state_nxt = P_ABS;
        end
      end
      P_ABS: begin
        ax_nxt    = adx[31:0];
        ay_nxt    = ady[31:0];
        s_nxt     = adx[31] | ady[31];
        state_nxt = P_SQ;
      end
      P_SQ: begin
        sqx_nxt   = axs * axs;
        sqy_nxt   = ays * ays;
        state_nxt = P_SUM;
      end
      P_SUM: begin
        sq_start  = 1'b1;
        state_nxt = P_ROOT;
      end
      P_ROOT: begin
        if (sq_done) begin
          r_nxt     = s_r ? {sq_root, 1'b0} : {1'b0, sq_root};
          state_nxt = P_CHK;
        end
      end
      P_CHK: begin
        // Coincident bodies are skipped.
        if (r_r == '0) begin
          state_nxt = P_IDLE;
        end else begin
          dt_start  = 1'b1;
          du_start  = 1'b1;
          state_nxt = P_DIV;
        end
      end
      P_DIV: begin
        if (dt_done && dux_done && duy_done) begin
          t_nxt     = dt_q[47:0];
          ux_nxt    = dux_q[prs_pkg::U_W-1:0];
          uy_nxt    = duy_q[prs_pkg::U_W-1:0];
          state_nxt = P_G;
        end
      end
      P_G: begin
        dt_dvd    = {t_r, 16'b0};
        dt_start  = 1'b1;
        state_nxt = P_GW;
      end
      P_GW: begin
        if (dt_done) begin
          // Clamp m/r^2 to 2^40.
          if ((|dt_q[63:41]) || (dt_q[40] && (|dt_q[39:0]))) begin
            g_nxt = {1'b1, {(prs_pkg::G_W-1){1'b0}}};
          end else begin
            g_nxt = dt_q[prs_pkg::G_W-1:0];
          end
          state_nxt = P_MUL;
        end
      end
      P_MUL: begin
        px_nxt    = g_r * ux_r;
        py_nxt    = g_r * uy_r;
        state_nxt = P_OUT;
      end
      P_OUT: begin
        state_nxt = P_IDLE;
      end
      default: begin
        state_nxt = P_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= P_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    dx_r  <= dx_nxt;
    dy_r  <= dy_nxt;
    m_r   <= m_nxt;
    ax_r  <= ax_nxt;
    ay_r  <= ay_nxt;
    s_r   <= s_nxt;
    sqx_r <= sqx_nxt;
    sqy_r <= sqy_nxt;
    r_r   <= r_nxt;
    t_r   <= t_nxt;
    ux_r  <= ux_nxt;
    uy_r  <= uy_nxt;
    g_r   <= g_nxt;
    px_r  <= px_nxt;
    py_r  <= py_nxt;
  end

  always_comb begin
    res.done  = (state_r == P_OUT) || ((state_r == P_CHK) && (r_r == '0));
    res.skip  = (state_r == P_CHK);
    res.mag_x = px_r[16 +: prs_pkg::MAG_W];
    res.mag_y = py_r[16 +: prs_pkg::MAG_W];
    res.x_pos = !dx_r[32] && (dx_r != '0);
    res.x_neg = dx_r[32];
    res.y_pos = !dy_r[32] && (dy_r != '0);
    res.y_neg = dy_r[32];
  end

endmodule

// ===== src/pairwise_repulsion_step_unit.sv =====
// Top level of the pairwise repulsion step unit: sequencer and body table.
// Depends on prs_pkg, prs_mem and prs_pair.
//
// The unit holds up to MAX_BODIES bodies (position in Q16.16, mass, age) in
// a single-port-read, single-port-write table. A write item stores a body and
// a read item returns one. A step item walks the first min(body_count,
// MAX_BODIES) entries in order: it reads body i, runs every other body j
// through the pair unit, then writes i back moved, saturated and one step
// older, so later bodies see the moved position. For each pair the pair unit
// runs a 32-step square root followed by two rounds of 64-step restoring
// division (m/r together with both unit vector components, then m/r^2),
// after the table read and setup. A pair at zero distance stops after the
// root. The table is not cleared at reset; an entry must be written before
// it is read or stepped. Inputs are taken only while the sequencer is idle;
// a finished result waits in the output register without blocking the next
// item from being taken, though that item cannot finish until it is free.
// body_count is written through cfg_we and cfg_wdata; the user must do so
// only while the unit is idle, as the unit itself does not enforce it.
module pairwise_repulsion_step_unit (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  prs_pkg::in_item_t     in_item,
  output logic                  out_valid,
  input  logic                  out_stall,
  output prs_pkg::out_item_t    out_item,
  input  logic                  cfg_we,
  input  logic [prs_pkg::BCNT_W-1:0] cfg_wdata
);

  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001,
    S_RD   = 9'b000000010,
    S_RDI  = 9'b000000100,
    S_LDI  = 9'b000001000,
    S_RDJ  = 9'b000010000,
    S_LDJ  = 9'b000100000,
    S_PAIR = 9'b001000000,
    S_WB   = 9'b010000000,
    S_DONE = 9'b100000000
  } state_t;

  localparam int SUM_W = prs_pkg::ACC_W + 1;

  state_t state_r, state_nxt;

  logic [prs_pkg::BCNT_W-1:0]          count_r, count_nxt;
  logic [prs_pkg::CNT_W-1:0]           n_r, n_nxt, i_r, i_nxt, j_r, j_nxt;
  logic signed [prs_pkg::POS_W-1:0]    xi_r, xi_nxt, yi_r, yi_nxt;
  logic [prs_pkg::MASS_W-1:0]          mi_r, mi_nxt;
  logic [prs_pkg::AGE_W-1:0]           agei_r, agei_nxt;
  logic signed [prs_pkg::ACC_W-1:0]    accx_r, accx_nxt, accy_r, accy_nxt;
  logic                                sat_r, sat_nxt;
  prs_pkg::out_item_t                  res_r, res_nxt;
  logic                                out_valid_r, out_valid_nxt;
  prs_pkg::out_item_t                  out_item_r, out_item_nxt;

  logic                                mem_we;
  logic [prs_pkg::IDX_W-1:0]           mem_waddr, mem_raddr;
  prs_pkg::body_t                      mem_wdata, mem_rdata;
  logic                                pair_start;
  prs_pkg::pair_res_t                  pair_res;

  logic                                in_fire, idx_ok;
  logic [prs_pkg::ACC_W-1:0]           magx_ext, magy_ext;
  logic [prs_pkg::POS_W:0]             newx, newy;

  // Returns {saturated, value}: old position plus accumulated displacement.
  function automatic logic [prs_pkg::POS_W:0] sat_add(
    input logic signed [prs_pkg::POS_W-1:0] pos,
    input logic signed [prs_pkg::ACC_W-1:0] acc
  );
    logic signed [SUM_W-1:0] sum;
    logic [SUM_W-prs_pkg::POS_W:0] top;
    sum = $signed({{(SUM_W-prs_pkg::POS_W){pos[prs_pkg::POS_W-1]}}, pos}) +
          $signed({acc[prs_pkg::ACC_W-1], acc});
    top = sum[SUM_W-1:prs_pkg::POS_W-1];
    if ((&top) || !(|top)) begin
      sat_add = {1'b0, sum[prs_pkg::POS_W-1:0]};
    end else if (sum[SUM_W-1]) begin
      sat_add = {1'b1, 1'b1, {(prs_pkg::POS_W-1){1'b0}}};
    end else begin
      sat_add = {1'b1, 1'b0, {(prs_pkg::POS_W-1){1'b1}}};
    end
  endfunction

  prs_mem u_mem (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (mem_waddr),
    .wr_data (mem_wdata),
    .rd_addr (mem_raddr),
    .rd_data (mem_rdata)
  );

  prs_pair u_pair (
    .clk   (clk),
    .rst_n (rst_n),
    .start (pair_start),
    .xi    (xi_r),
    .yi    (yi_r),
    .xj    (mem_rdata.pos_x),
    .yj    (mem_rdata.pos_y),
    .mj    (mem_rdata.mass),
    .res   (pair_res)
  );

  assign in_stall = (state_r != S_IDLE);
  assign in_fire  = in_valid && !in_stall;
  assign idx_ok   = (32'(in_item.body_index) < prs_pkg::MAX_BODIES);
  assign magx_ext = prs_pkg::ACC_W'(pair_res.mag_x);
  assign magy_ext = prs_pkg::ACC_W'(pair_res.mag_y);
  assign newx     = sat_add(xi_r, accx_r);
  assign newy     = sat_add(yi_r, accy_r);

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    n_nxt         = n_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    xi_nxt        = xi_r;
    yi_nxt        = yi_r;
    mi_nxt        = mi_r;
    agei_nxt      = agei_r;
    accx_nxt      = accx_r;
    accy_nxt      = accy_r;
    sat_nxt       = sat_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r;
    out_item_nxt  = out_item_r;
    mem_we        = 1'b0;
    mem_waddr     = prs_pkg::IDX_W'(in_item.body_index);
    mem_wdata.pos_x = in_item.pos_x;
    mem_wdata.pos_y = in_item.pos_y;
    mem_wdata.mass  = in_item.body_mass;
    mem_wdata.age   = in_item.body_age;
    mem_raddr     = prs_pkg::IDX_W'(in_item.body_index);
    pair_start    = 1'b0;

    if (cfg_we) begin
      count_nxt = cfg_wdata;
    end

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          res_nxt   = '0;
          state_nxt = S_DONE;
          unique case (in_item.func)
            prs_pkg::FUNC_WRITE: begin
              mem_we = idx_ok;
            end
            prs_pkg::FUNC_READ: begin
              if (idx_ok) begin
                state_nxt = S_RD;
              end
            end
            prs_pkg::FUNC_STEP: begin
              sat_nxt = 1'b0;
              i_nxt   = '0;
              if (32'(count_r) > prs_pkg::MAX_BODIES) begin
                n_nxt = prs_pkg::CNT_W'(prs_pkg::MAX_BODIES);
              end else begin
                n_nxt = prs_pkg::CNT_W'(count_r);
              end
              if (count_r != '0) begin
                state_nxt = S_RDI;
              end
            end
            default: begin
              // unused code: nothing changes, result is all zeros
            end
          endcase
        end
      end
      S_RD: begin
        res_nxt.out_x    = mem_rdata.pos_x;
        res_nxt.out_y    = mem_rdata.pos_y;
        res_nxt.out_mass = mem_rdata.mass;
        res_nxt.out_age  = mem_rdata.age;
        res_nxt.status   = 1'b0;
        state_nxt        = S_DONE;
      end
      S_RDI: begin
        mem_raddr = i_r[prs_pkg::IDX_W-1:0];
        state_nxt = S_LDI;
      end
      S_LDI: begin
        xi_nxt    = mem_rdata.pos_x;
        yi_nxt    = mem_rdata.pos_y;
        mi_nxt    = mem_rdata.mass;
        agei_nxt  = mem_rdata.age;
        accx_nxt  = '0;
        accy_nxt  = '0;
        j_nxt     = '0;
        state_nxt = S_RDJ;
      end
      S_RDJ: begin
        if (j_r == n_r) begin
          state_nxt = S_WB;
        end else if (j_r == i_r) begin
          j_nxt = j_r + prs_pkg::CNT_W'(1);
        end else begin
          mem_raddr = j_r[prs_pkg::IDX_W-1:0];
          state_nxt = S_LDJ;
        end
      end
      S_LDJ: begin
        pair_start = 1'b1;
        state_nxt  = S_PAIR;
      end
      S_PAIR: begin
        if (pair_res.done) begin
          if (!pair_res.skip) begin
            // Repulsion: push away from the other body.
            if (pair_res.x_pos) begin
              accx_nxt = accx_r - $signed(magx_ext);
            end else if (pair_res.x_neg) begin
              accx_nxt = accx_r + $signed(magx_ext);
            end
            if (pair_res.y_pos) begin
              accy_nxt = accy_r - $signed(magy_ext);
            end else if (pair_res.y_neg) begin
              accy_nxt = accy_r + $signed(magy_ext);
            end
          end
          j_nxt     = j_r + prs_pkg::CNT_W'(1);
          state_nxt = S_RDJ;
        end
      end
      S_WB: begin
        mem_we          = 1'b1;
        mem_waddr       = i_r[prs_pkg::IDX_W-1:0];
        mem_wdata.pos_x = newx[prs_pkg::POS_W-1:0];
        mem_wdata.pos_y = newy[prs_pkg::POS_W-1:0];
        mem_wdata.mass  = mi_r;
        mem_wdata.age   = agei_r + prs_pkg::AGE_W'(1);
        sat_nxt         = sat_r | newx[prs_pkg::POS_W] | newy[prs_pkg::POS_W];
        i_nxt           = i_r + prs_pkg::CNT_W'(1);
        if ((i_r + prs_pkg::CNT_W'(1)) == n_r) begin
          res_nxt        = '0;
          res_nxt.status = sat_nxt;
          state_nxt      = S_DONE;
        end else begin
          state_nxt = S_RDI;
        end
      end
      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_item_nxt  = res_r;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
      n_r         <= '0;
      i_r         <= '0;
      j_r         <= '0;
      sat_r       <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
      n_r         <= n_nxt;
      i_r         <= i_nxt;
      j_r         <= j_nxt;
      sat_r       <= sat_nxt;
    end
    xi_r       <= xi_nxt;
    yi_r       <= yi_nxt;
    mi_r       <= mi_nxt;
    agei_r     <= agei_nxt;
    accx_r     <= accx_nxt;
    accy_r     <= accy_nxt;
    res_r      <= res_nxt;
    out_item_r <= out_item_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

`ifndef SYNTHESIS
  a_no_self_pair: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_LDJ) |-> (j_r != i_r))
    else $error("body paired with itself");

  a_wb_after_all: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WB) |-> (j_r == n_r))
    else $error("body written back before all pairs were visited");

  a_pair_done_owned: assert property (@(posedge clk) disable iff (!rst_n)
    pair_res.done |-> (state_r == S_PAIR))
    else $error("pair result arrived outside the pair wait state");

  a_i_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_LDI) |-> (i_r < n_r))
    else $error("body index beyond active count");
`endif

endmodule
